/* sv/assert_macros.svh */
// Assertion macros used by the checker file of the meter.
// Needs nothing else; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/pwmfdm_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the PWM frequency and duty meter.
// No dependencies; the top, front end, queue and back end refer to it by scoped names.
package pwmfdm_pkg;

    localparam int COUNT_WIDTH_DEF    = 16;
    localparam int FILTER_SAMPLES_DEF = 4;

    localparam int CLK_W  = 25;
    localparam int FREQ_W = 15;
    localparam int DUTY_W = 7;

    localparam logic [CLK_W-1:0] CLOCK_HZ_RESET = 25'd8000000;
    localparam int FREQ_MAX = 32767;
    localparam int DUTY_MAX = 100;
    localparam int KHZ_DIV  = 1000;
    localparam int PCT_MUL  = 100;

    // APB register map
    localparam int CFG_AW       = 3;
    localparam int REG_CLOCK_HZ = 0;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_WAIT_A = 4'b0010,
        PH_WAIT_B = 4'b0100,
        PH_WAIT_C = 4'b1000
    } t_phase;

    typedef enum logic [4:0] {
        BK_IDLE  = 5'b00001,
        BK_MUL   = 5'b00010,
        BK_DIV_F = 5'b00100,
        BK_DIV_D = 5'b01000,
        BK_OUT   = 5'b10000
    } t_back_state;

endpackage

/* sv/pwm_frequency_duty_meter.sv */
`timescale 1ns / 1ps
// Top level of the PWM frequency and duty meter: APB register, front end,
// queue and arithmetic back end. Uses pwmfdm_pkg and the pwmfdm_* modules.
//
// Input capture meter. Each slave-side transfer is one timer tick carrying a
// level sample (tuser 0) or a start command (tuser 1); ticks are taken one per
// clock. A 4-sample qualifier cleans the level, and the tick counter is
// captured at two successive qualified rising edges and the falling edge that
// follows. A finished capture set goes into a two-entry queue; the back end
// turns it into frequency (clock_hz over period, in kHz) and duty (percent,
// saturated at 100), or flags out_of_range when the captures do not increase,
// e.g. after a counter wrap. The back end's bit-serial divider sets the cost
// of a measurement: one division for frequency and one for duty, each DW bits
// wide with DW = max(25, COUNT_WIDTH+7), plus any output stall. Ticks keep
// being accepted meanwhile; s_tready drops only while the queue is full.
// clock_hz sits at byte address 0; write it only while the meter is idle (unenforced).
module pwm_frequency_duty_meter #(
    parameter int COUNT_WIDTH    = pwmfdm_pkg::COUNT_WIDTH_DEF,
    parameter int FILTER_SAMPLES = pwmfdm_pkg::FILTER_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // [0] signal_level, [7:1] zero
    input  logic                          i_s_tuser,   // [0] command
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [23:0]                   o_m_tdata,   // [14:0] freq_khz,
                                                       // [21:15] duty_percent, [23:22] zero
    output logic                          o_m_tuser,   // [0] out_of_range
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pwmfdm_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int EW = 2 * COUNT_WIDTH + 1;

    logic [pwmfdm_pkg::CLK_W-1:0]  r_clock_hz;
    logic                          w_sel_clock;
    logic                          w_push;
    logic                          w_pop;
    logic [EW-1:0]                 w_entry_in;
    logic [EW-1:0]                 w_entry_out;
    pwmfdm_pkg::t_q_status         w_q_status;
    logic [pwmfdm_pkg::FREQ_W-1:0] w_freq;
    logic [pwmfdm_pkg::DUTY_W-1:0] w_duty;

    assign pready      = 1'b1;
    assign w_sel_clock = (paddr[pwmfdm_pkg::CFG_AW-1:2] == 1'(pwmfdm_pkg::REG_CLOCK_HZ));
    assign prdata      = w_sel_clock ? 32'(r_clock_hz) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= pwmfdm_pkg::CLOCK_HZ_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_clock) begin
            r_clock_hz <= pwdata[pwmfdm_pkg::CLK_W-1:0];
        end
    end

    pwmfdm_front #(
        .COUNT_WIDTH    (COUNT_WIDTH),
        .FILTER_SAMPLES (FILTER_SAMPLES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .i_cmd      (i_s_tuser),
        .i_level    (i_s_tdata[0]),
        .i_q_status (w_q_status),
        .o_ready    (o_s_tready),
        .o_push     (w_push),
        .o_entry    (w_entry_in)
    );

    pwmfdm_queue #(
        .WIDTH (EW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_entry_in),
        .i_pop    (w_pop),
        .o_data   (w_entry_out),
        .o_status (w_q_status)
    );

    pwmfdm_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (w_q_status),
        .i_entry     (w_entry_out),
        .o_pop       (w_pop),
        .i_clock_hz  (r_clock_hz),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_freq      (w_freq),
        .o_duty      (w_duty),
        .o_oor       (o_m_tuser)
    );

    assign o_m_tdata = {2'b00, w_duty, w_freq};

endmodule

/* sv/pwmfdm_front.sv */
`timescale 1ns / 1ps
// Front end: sample qualifier, tick counter and edge capture sequence.
// Uses pwmfdm_pkg; pushes finished capture sets into pwmfdm_queue.
module pwmfdm_front #(
    parameter int COUNT_WIDTH    = pwmfdm_pkg::COUNT_WIDTH_DEF,
    parameter int FILTER_SAMPLES = pwmfdm_pkg::FILTER_SAMPLES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_cmd,
    input  logic                      i_level,
    input  pwmfdm_pkg::t_q_status     i_q_status,
    output logic                      o_ready,
    output logic                      o_push,
    output logic [2*COUNT_WIDTH:0]    o_entry     // {ok, high time, period}
);

    localparam int HW = (FILTER_SAMPLES > 1) ? FILTER_SAMPLES - 1 : 1;

    logic [COUNT_WIDTH-1:0]    r_tick, n_tick;
    logic [COUNT_WIDTH-1:0]    r_first, n_first;
    logic [COUNT_WIDTH-1:0]    r_second, n_second;
    pwmfdm_pkg::t_phase        r_phase, n_phase;
    logic [HW-1:0]             r_hist, n_hist;
    logic                      r_qual, n_qual;

    logic [FILTER_SAMPLES-1:0] w_window;
    logic [HW-1:0]             w_hist_next;
    logic                      w_accept;
    logic                      w_rise;
    logic                      w_fall;
    logic                      w_ok;

    generate
        if (FILTER_SAMPLES > 1) begin : g_hist
            assign w_window    = {r_hist[FILTER_SAMPLES-2:0], i_level};
            assign w_hist_next = w_window[FILTER_SAMPLES-2:0];
        end else begin : g_nohist
            assign w_window    = i_level;
            assign w_hist_next = r_hist;
        end
    endgenerate

    assign o_ready  = !i_q_status.full;
    assign w_accept = i_valid && o_ready;
    assign w_rise   = (w_window == '1) && !r_qual;
    assign w_fall   = (w_window == '0) && r_qual;

    // current count is the fall capture C
    assign w_ok    = (r_first < r_second) && (r_second < r_tick);
    assign o_entry = {w_ok, r_tick - r_second, r_second - r_first};

    always_comb begin
        n_tick   = r_tick;
        n_first  = r_first;
        n_second = r_second;
        n_phase  = r_phase;
        n_hist   = r_hist;
        n_qual   = r_qual;
        o_push   = 1'b0;
        if (w_accept) begin
            if (i_cmd) begin
                n_tick  = '0;
                n_phase = pwmfdm_pkg::PH_WAIT_A;
            end else begin
                n_hist = w_hist_next;
                if (w_rise) begin
                    n_qual = 1'b1;
                end else if (w_fall) begin
                    n_qual = 1'b0;
                end
                case (r_phase)
                    pwmfdm_pkg::PH_WAIT_A: begin
                        if (w_rise) begin
                            n_first = r_tick;
                            n_phase = pwmfdm_pkg::PH_WAIT_B;
                        end
                    end
                    pwmfdm_pkg::PH_WAIT_B: begin
                        if (w_rise) begin
                            n_second = r_tick;
                            n_phase  = pwmfdm_pkg::PH_WAIT_C;
                        end
                    end
                    pwmfdm_pkg::PH_WAIT_C: begin
                        if (w_fall) begin
                            o_push  = 1'b1;
                            n_phase = pwmfdm_pkg::PH_IDLE;
                        end
                    end
                    default: ;
                endcase
                n_tick = r_tick + COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_phase <= pwmfdm_pkg::PH_IDLE;
            r_hist  <= '0;
            r_qual  <= 1'b0;
        end else begin
            r_tick  <= n_tick;
            r_phase <= n_phase;
            r_hist  <= n_hist;
            r_qual  <= n_qual;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first  <= n_first;
        r_second <= n_second;
    end

endmodule

/* sv/pwmfdm_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue between the capture front end and the arithmetic back end.
// Uses pwmfdm_pkg for depth, pointer widths and the status struct.
module pwmfdm_queue #(
    parameter int WIDTH = 2 * pwmfdm_pkg::COUNT_WIDTH_DEF + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [WIDTH-1:0]      i_data,
    input  logic                  i_pop,
    output logic [WIDTH-1:0]      o_data,
    output pwmfdm_pkg::t_q_status o_status
);

    logic [WIDTH-1:0]              r_mem [pwmfdm_pkg::QUEUE_DEPTH];
    logic [pwmfdm_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [pwmfdm_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [pwmfdm_pkg::QCNT_W-1:0] r_count;

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == pwmfdm_pkg::QCNT_W'(pwmfdm_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // push only when not full, pop only when not empty: the neighbours see to it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + pwmfdm_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + pwmfdm_pkg::QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + pwmfdm_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - pwmfdm_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/pwmfdm_back.sv */
`timescale 1ns / 1ps
// Back end: turns a capture set into frequency and duty with a shared bit-serial
// restoring divider, or flags out_of_range; holds the result. Uses pwmfdm_pkg.
module pwmfdm_back #(
    parameter int COUNT_WIDTH = pwmfdm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pwmfdm_pkg::t_q_status            i_q_status,
    input  logic [2*COUNT_WIDTH:0]           i_entry,
    output logic                             o_pop,
    input  logic [pwmfdm_pkg::CLK_W-1:0]     i_clock_hz,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [pwmfdm_pkg::FREQ_W-1:0]    o_freq,
    output logic [pwmfdm_pkg::DUTY_W-1:0]    o_duty,
    output logic                             o_oor
);

    // divisor period*1000 (1000 < 2^10) or period, dividend clock_hz or high*100
    localparam int DVW   = COUNT_WIDTH + 10;
    localparam int DW    = (COUNT_WIDTH + 7 > pwmfdm_pkg::CLK_W) ?
                           COUNT_WIDTH + 7 : pwmfdm_pkg::CLK_W;
    localparam int CNT_W = $clog2(DW + 1);

    pwmfdm_pkg::t_back_state r_state;

    logic [COUNT_WIDTH-1:0]        r_period;
    logic [COUNT_WIDTH-1:0]        r_high;
    logic                          r_ok;
    logic [DW-1:0]                 r_num_d;
    logic [DVW-1:0]                r_den;
    logic [DVW-1:0]                r_rem;
    logic [DW-1:0]                 r_quo;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_out_valid;
    logic [pwmfdm_pkg::FREQ_W-1:0] r_freq;
    logic [pwmfdm_pkg::DUTY_W-1:0] r_duty;
    logic                          r_oor;

    logic [DVW:0]   w_shift;
    logic [DVW:0]   w_diff;
    logic           w_ge;
    logic [DVW-1:0] n_rem;
    logic [DW-1:0]  n_quo;
    logic           w_div_done;

    // one quotient bit a cycle
    assign w_shift    = {r_rem, r_quo[DW-1]};
    assign w_diff     = w_shift - {1'b0, r_den};
    assign w_ge       = (w_shift >= {1'b0, r_den});
    assign n_rem      = w_ge ? w_diff[DVW-1:0] : w_shift[DVW-1:0];
    assign n_quo      = {r_quo[DW-2:0], w_ge};
    assign w_div_done = (r_cnt == '0);

    assign o_pop       = (r_state == pwmfdm_pkg::BK_IDLE) && !i_q_status.empty;
    assign o_out_valid = r_out_valid;
    assign o_freq      = r_freq;
    assign o_duty      = r_duty;
    assign o_oor       = r_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pwmfdm_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            case (r_state)
                pwmfdm_pkg::BK_IDLE: begin
                    if (o_pop) begin
                        r_period <= i_entry[COUNT_WIDTH-1:0];
                        r_high   <= i_entry[2*COUNT_WIDTH-1:COUNT_WIDTH];
                        r_ok     <= i_entry[2*COUNT_WIDTH];
                        r_state  <= pwmfdm_pkg::BK_MUL;
                    end
                end
                pwmfdm_pkg::BK_MUL: begin
                    if (r_ok) begin
                        // floor(floor(x/p)/1000) equals floor(x/(p*1000))
                        r_den   <= DVW'(r_period) * DVW'(pwmfdm_pkg::KHZ_DIV);
                        r_num_d <= DW'(r_high) * DW'(pwmfdm_pkg::PCT_MUL);
                        r_quo   <= DW'(i_clock_hz);
                        r_rem   <= '0;
                        r_cnt   <= CNT_W'(DW);
                        r_state <= pwmfdm_pkg::BK_DIV_F;
                    end else begin
                        r_freq      <= '0;
                        r_duty      <= '0;
                        r_oor       <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_state     <= pwmfdm_pkg::BK_OUT;
                    end
                end
                pwmfdm_pkg::BK_DIV_F: begin
                    if (w_div_done) begin
                        r_freq  <= (r_quo > DW'(pwmfdm_pkg::FREQ_MAX)) ?
                                   pwmfdm_pkg::FREQ_W'(pwmfdm_pkg::FREQ_MAX) :
                                   r_quo[pwmfdm_pkg::FREQ_W-1:0];
                        r_quo   <= r_num_d;
                        r_rem   <= '0;
                        r_den   <= DVW'(r_period);
                        r_cnt   <= CNT_W'(DW);
                        r_state <= pwmfdm_pkg::BK_DIV_D;
                    end else begin
                        r_quo <= n_quo;
                        r_rem <= n_rem;
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                pwmfdm_pkg::BK_DIV_D: begin
                    if (w_div_done) begin
                        r_duty      <= (r_quo > DW'(pwmfdm_pkg::DUTY_MAX)) ?
                                       pwmfdm_pkg::DUTY_W'(pwmfdm_pkg::DUTY_MAX) :
                                       r_quo[pwmfdm_pkg::DUTY_W-1:0];
                        r_oor       <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_state     <= pwmfdm_pkg::BK_OUT;
                    end else begin
                        r_quo <= n_quo;
                        r_rem <= n_rem;
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                pwmfdm_pkg::BK_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= pwmfdm_pkg::BK_IDLE;
                    end
                end
                default: begin
                    r_state <= pwmfdm_pkg::BK_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/pwmfdm_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the PWM frequency and duty meter, bound to the top.
// Uses assert_macros.svh.
`include "assert_macros.svh"

module pwmfdm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        pready
);

    // a result is never withdrawn before its transfer
    `ASSERT_RUN(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "result dropped while stalled")
    // out_of_range results carry no numbers
    `ASSERT_RUN(a_oor_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser |-> o_m_tdata == 24'd0, "out_of_range with data")
    // duty saturates at 100 and the padding stays clear
    `ASSERT_RUN(a_duty_max, i_clk, i_rst_n, o_m_tvalid |-> o_m_tdata[21:15] <= 7'd100 && o_m_tdata[23:22] == 2'b00, "duty field out of range")
    // no result straight out of reset
    `ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")
    `ASSERT_ALWAYS(a_pready, i_clk, pready, "pready low")

endmodule

bind pwm_frequency_duty_meter pwmfdm_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .pready     (pready)
);
